/* rtl/srle_pkg.sv */
// Shared types and constants for the sprite row run-length encoder.
// No dependencies; all other files of the block but srle_ram use it by scoped names.
package srle_pkg;

	// Default for the longest run, in pixels.
	localparam int MAX_RUN_DEF = 127;

	// Run length field of a header byte.
	localparam int CNT_W = 7;

	// Depth of the command queue between front and back end (a power of two).
	localparam int CMD_DEPTH = 4;

	localparam int PIXEL_W = 8;
	localparam int WORD_W = 64;
	localparam int BCNT_W = 4;

	// Header flag of a transparent run, and the byte that closes every row.
	localparam logic [7:0] CLEAR_FLAG = 8'h80;
	localparam logic [7:0] ROW_END_BYTE = 8'h80;

	typedef enum logic [1:0] {
		CLOSE_NONE   = 2'd0,
		CLOSE_CLEAR  = 2'd1,
		CLOSE_OPAQUE = 2'd2
	} close_kind_t;

	// One run being closed: its kind, its length and the literal bank it sits in.
	typedef struct packed {
		close_kind_t       kind;
		logic [CNT_W-1:0]  count;
		logic              bank;
	} close_t;

	// Everything one pixel asks of the back end, in emission order.
	typedef struct packed {
		close_t  pre;
		close_t  post;
		logic    row_end;
	} cmd_t;

	// Back end tells the front end that a literal bank has been read out.
	typedef struct packed {
		logic  valid;
		logic  bank;
	} release_t;

endpackage

/* rtl/srle_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module srle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  logic [WIDTH-1:0]          wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/srle_fifo.sv */
// Small command queue between the front and back end of the encoder.
// Depends on srle_pkg for the command type and depth.
module srle_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srle_pkg::cmd_t  push_data,
	output logic            push_ready,
	input  logic            pop,
	output logic            pop_valid,
	output srle_pkg::cmd_t  pop_data
);

	localparam int PW = $clog2(srle_pkg::CMD_DEPTH);

	srle_pkg::cmd_t    entry_q [srle_pkg::CMD_DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [PW:0]       fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = fill_q != (PW+1)'(srle_pkg::CMD_DEPTH);
	assign pop_valid = fill_q != '0;
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (!do_push && do_pop) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

endmodule

/* rtl/srle_front.sv */
// Front end of the encoder: tracks the open run, stores opaque pixels and
// queues one command per pixel that produces output. Depends on srle_pkg.
module srle_front #(
	parameter int MAX_RUN = srle_pkg::MAX_RUN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [srle_pkg::PIXEL_W-1:0]       s_tdata,
	input  logic                               s_tlast,
	output logic                               cmd_push,
	output srle_pkg::cmd_t                     cmd_data,
	input  logic                               cmd_ready,
	input  srle_pkg::release_t                 rel,
	output logic                               ram_we,
	output logic [$clog2(2*MAX_RUN)-1:0]       ram_waddr,
	output logic [srle_pkg::PIXEL_W-1:0]       ram_wdata
);

	localparam int AW = $clog2(2*MAX_RUN);
	localparam int CW = srle_pkg::CNT_W;

	logic           run_open_q;
	logic           run_clear_q;
	logic [CW-1:0]  run_count_q;
	logic           wr_bank_q;
	logic [1:0]     pending_q;

	logic           accept;
	logic           pix_clear;
	logic           change;
	logic [CW-1:0]  base;
	logic [CW-1:0]  new_count;
	logic           full;
	logic           closes_run;
	logic           closes_opaque;
	logic [1:0]     pend_set;
	logic [1:0]     pend_clr;

	// A bank whose run still waits to be read out cannot take new pixels.
	assign s_tready = cmd_ready && !pending_q[wr_bank_q];
	assign accept = s_tvalid && s_tready;

	always_comb begin
		pix_clear = s_tdata == '0;
		change = run_open_q && (run_clear_q != pix_clear);
		base = (change || !run_open_q) ? '0 : run_count_q;
		new_count = base + CW'(1);
		full = new_count == CW'(MAX_RUN);
		closes_run = s_tlast || full;

		cmd_data.pre.kind = srle_pkg::CLOSE_NONE;
		if (change) begin
			cmd_data.pre.kind = run_clear_q ? srle_pkg::CLOSE_CLEAR : srle_pkg::CLOSE_OPAQUE;
		end
		cmd_data.pre.count = run_count_q;
		cmd_data.pre.bank = wr_bank_q;

		// A transparent run that reaches the row end is dropped.
		cmd_data.post.kind = srle_pkg::CLOSE_NONE;
		if (s_tlast) begin
			cmd_data.post.kind = pix_clear ? srle_pkg::CLOSE_NONE : srle_pkg::CLOSE_OPAQUE;
		end else if (full) begin
			cmd_data.post.kind = pix_clear ? srle_pkg::CLOSE_CLEAR : srle_pkg::CLOSE_OPAQUE;
		end
		cmd_data.post.count = new_count;
		cmd_data.post.bank = wr_bank_q;
		cmd_data.row_end = s_tlast;

		closes_opaque = (cmd_data.pre.kind == srle_pkg::CLOSE_OPAQUE)
			|| (cmd_data.post.kind == srle_pkg::CLOSE_OPAQUE);
		cmd_push = accept && ((cmd_data.pre.kind != srle_pkg::CLOSE_NONE)
			|| (cmd_data.post.kind != srle_pkg::CLOSE_NONE) || s_tlast);

		pend_set = 2'b00;
		pend_set[wr_bank_q] = accept && closes_opaque;
		pend_clr = 2'b00;
		pend_clr[rel.bank] = rel.valid;
	end

	// An opaque pixel never follows an opaque close in the same transfer, so the
	// current bank is always the one to write.
	assign ram_we = accept && !pix_clear;
	assign ram_waddr = wr_bank_q ? (AW'(MAX_RUN) + AW'(base)) : AW'(base);
	assign ram_wdata = s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			run_clear_q <= 1'b0;
			run_count_q <= '0;
			wr_bank_q <= 1'b0;
			pending_q <= 2'b00;
		end else begin
			if (accept) begin
				run_open_q <= !closes_run;
				run_clear_q <= closes_run ? 1'b0 : pix_clear;
				run_count_q <= closes_run ? '0 : new_count;
				if (closes_opaque) begin
					wr_bank_q <= ~wr_bank_q;
				end
			end
			pending_q <= (pending_q & ~pend_clr) | pend_set;
		end
	end

endmodule

/* rtl/srle_back.sv */
// Back end (depends on srle_pkg): walks queued commands one byte per cycle unless the
// output stalls, reads literal pixels from the store and packs bytes into output words.
module srle_back #(
	parameter int MAX_RUN = srle_pkg::MAX_RUN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	input  srle_pkg::cmd_t                     cmd_in,
	output logic                               cmd_pop,
	output srle_pkg::release_t                 rel,
	output logic                               ram_re,
	output logic [$clog2(2*MAX_RUN)-1:0]       ram_raddr,
	input  logic [srle_pkg::PIXEL_W-1:0]       ram_rdata,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [srle_pkg::WORD_W-1:0]        out_bytes,
	output logic [srle_pkg::BCNT_W-1:0]        out_count,
	output logic                               out_last
);

	localparam int AW = $clog2(2*MAX_RUN);
	localparam int CW = srle_pkg::CNT_W;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_A_HDR = 6'b000010,
		PH_A_LIT = 6'b000100,
		PH_B_HDR = 6'b001000,
		PH_B_LIT = 6'b010000,
		PH_ROW   = 6'b100000
	} phase_t;

	phase_t          phase_q;
	phase_t          next_phase;
	phase_t          first_phase;
	phase_t          after_a;
	phase_t          after_b;
	srle_pkg::cmd_t  cmd_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   idx_next;

	srle_pkg::close_t  cur;
	logic              tok_valid;
	logic              tok_lit;
	logic [7:0]        tok_byte;
	logic              last_lit;

	logic        s1_valid_s1;
	logic        s1_lit_s1;
	logic        s1_end_s1;
	logic [7:0]  s1_byte_s1;
	logic [7:0]  pk_byte;

	logic [srle_pkg::WORD_W-1:0]  word_q;
	logic [2:0]                   fill_q;
	logic [srle_pkg::WORD_W-1:0]  word_ins;
	logic                         flush;
	logic                         take;
	logic                         adv;
	logic                         out_valid_q;
	logic [srle_pkg::WORD_W-1:0]  out_bytes_q;
	logic [srle_pkg::BCNT_W-1:0]  out_count_q;
	logic                         out_last_q;

	always_comb begin
		cur = (phase_q == PH_A_HDR || phase_q == PH_A_LIT) ? cmd_q.pre : cmd_q.post;
		last_lit = idx_q == (cur.count - CW'(1));
		after_b = cmd_q.row_end ? PH_ROW : PH_IDLE;
		after_a = (cmd_q.post.kind != srle_pkg::CLOSE_NONE) ? PH_B_HDR : after_b;

		if (cmd_in.pre.kind != srle_pkg::CLOSE_NONE) begin
			first_phase = PH_A_HDR;
		end else if (cmd_in.post.kind != srle_pkg::CLOSE_NONE) begin
			first_phase = PH_B_HDR;
		end else begin
			first_phase = PH_ROW;
		end

		tok_valid = 1'b1;
		tok_lit = 1'b0;
		tok_byte = '0;
		next_phase = PH_IDLE;
		idx_next = idx_q;
		unique case (phase_q)
			PH_IDLE: begin
				tok_valid = 1'b0;
			end
			PH_A_HDR, PH_B_HDR: begin
				tok_byte = (cur.kind == srle_pkg::CLOSE_CLEAR)
					? (srle_pkg::CLEAR_FLAG | {1'b0, cur.count}) : {1'b0, cur.count};
				idx_next = '0;
				if (cur.kind == srle_pkg::CLOSE_OPAQUE) begin
					next_phase = (phase_q == PH_A_HDR) ? PH_A_LIT : PH_B_LIT;
				end else begin
					next_phase = (phase_q == PH_A_HDR) ? after_a : after_b;
				end
			end
			PH_A_LIT, PH_B_LIT: begin
				tok_lit = 1'b1;
				idx_next = idx_q + CW'(1);
				if (last_lit) begin
					next_phase = (phase_q == PH_A_LIT) ? after_a : after_b;
				end else begin
					next_phase = phase_q;
				end
			end
			PH_ROW: begin
				tok_byte = srle_pkg::ROW_END_BYTE;
			end
			default: begin
				tok_valid = 1'b0;
			end
		endcase
	end

	// The byte stage moves on when it is empty or its byte enters the packer.
	assign pk_byte = s1_lit_s1 ? ram_rdata : s1_byte_s1;
	assign flush = (fill_q == 3'd7) || s1_end_s1;
	assign take = s1_valid_s1 && (!flush || !out_valid_q || out_ready);
	assign adv = !s1_valid_s1 || take;
	assign word_ins = word_q | ({{(srle_pkg::WORD_W-8){1'b0}}, pk_byte} << {fill_q, 3'b000});

	assign cmd_pop = (phase_q == PH_IDLE) && cmd_valid;
	assign ram_re = adv && tok_lit;
	assign ram_raddr = cur.bank ? (AW'(MAX_RUN) + AW'(idx_q)) : AW'(idx_q);

	// The bank is free once its last read is issued; the front end writes no sooner
	// than the next cycle.
	assign rel.valid = adv && tok_lit && last_lit;
	assign rel.bank = cur.bank;

	assign out_valid = out_valid_q;
	assign out_bytes = out_bytes_q;
	assign out_count = out_count_q;
	assign out_last = out_last_q;

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd_in;
		end
		if (adv) begin
			s1_lit_s1 <= tok_lit;
			s1_byte_s1 <= tok_byte;
			s1_end_s1 <= next_phase == PH_IDLE;
		end
		if (take && flush) begin
			out_bytes_q <= word_ins;
			out_count_q <= {1'b0, fill_q} + srle_pkg::BCNT_W'(1);
			out_last_q <= s1_end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q <= '0;
			s1_valid_s1 <= 1'b0;
			word_q <= '0;
			fill_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (phase_q == PH_IDLE) begin
				if (cmd_valid) begin
					phase_q <= first_phase;
				end
			end else if (adv) begin
				phase_q <= next_phase;
				idx_q <= idx_next;
			end
			if (adv) begin
				s1_valid_s1 <= tok_valid;
			end
			if (take) begin
				if (flush) begin
					word_q <= '0;
					fill_q <= '0;
				end else begin
					word_q <= word_ins;
					fill_q <= fill_q + 3'd1;
				end
			end
			if (take && flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/sprite_row_rle_encoder.sv */
// Sprite row run-length encoder. Pixels (8-bit palette indexes, zero is
// transparent) enter on the s_ side with s_tlast on each row's last pixel; encoded
// bytes leave on the m_ side packed up to eight per word, m_tlast marking the final
// word caused by one input pixel. The front end takes one pixel per cycle as long as
// its four-entry command queue has room and the literal bank it writes into has been
// read out; opaque runs alternate between two banks of the literal store, so one run
// can fill while the previous one drains. The back end emits one encoded byte per
// cycle while the output is not stalled, limited by the single read port of the
// literal store, and passes through an idle state to fetch each queued command; a
// closing opaque run thus occupies the back end for its header, its literal bytes
// and that fetch. Depends on srle_pkg, srle_front, srle_fifo, srle_back and srle_ram.
module sprite_row_rle_encoder #(
	parameter int MAX_RUN = srle_pkg::MAX_RUN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	input  logic        s_tlast,   // row_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] packed_bytes, [67:64] byte_count, rest zero
	output logic        m_tlast    // last
);

	localparam int AW = $clog2(2*MAX_RUN);

	logic                          cmd_push;
	srle_pkg::cmd_t                cmd_push_data;
	logic                          cmd_ready;
	logic                          cmd_pop;
	logic                          cmd_valid;
	srle_pkg::cmd_t                cmd_pop_data;
	srle_pkg::release_t            rel;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [srle_pkg::PIXEL_W-1:0]  ram_wdata;
	logic                          ram_re;
	logic [AW-1:0]                 ram_raddr;
	logic [srle_pkg::PIXEL_W-1:0]  ram_rdata;
	logic [srle_pkg::WORD_W-1:0]   out_bytes;
	logic [srle_pkg::BCNT_W-1:0]   out_count;

	srle_front #(.MAX_RUN(MAX_RUN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cmd_push  (cmd_push),
		.cmd_data  (cmd_push_data),
		.cmd_ready (cmd_ready),
		.rel       (rel),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	srle_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.push_data  (cmd_push_data),
		.push_ready (cmd_ready),
		.pop        (cmd_pop),
		.pop_valid  (cmd_valid),
		.pop_data   (cmd_pop_data)
	);

	srle_ram #(.WIDTH(srle_pkg::PIXEL_W), .DEPTH(2*MAX_RUN)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	srle_back #(.MAX_RUN(MAX_RUN)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_in    (cmd_pop_data),
		.cmd_pop   (cmd_pop),
		.rel       (rel),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_bytes (out_bytes),
		.out_count (out_count),
		.out_last  (m_tlast)
	);

	assign m_tdata = {4'b0000, out_count, out_bytes};

endmodule
